### sv/bed_pkg.sv
// Shared types, constants and codes for the bounded edit distance block.
package bed_pkg;

   localparam int MAX_LEN = 64;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int THR_W   = 8;
   localparam int CMP_W   = (LEN_W > THR_W) ? LEN_W : THR_W;
   localparam logic [THR_W-1:0] THR_RESET = 8'd30;

   localparam logic [1:0] OP_APPEND_A = 2'd0;
   localparam logic [1:0] OP_APPEND_B = 2'd1;
   localparam logic [1:0] OP_COMPUTE  = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] symbol;
   } bed_req_type;

   typedef struct packed {
      logic [7:0] distance;
      logic       overflow;
   } bed_rsp_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic j_clear;
      logic j_one;
      logic j_inc;
      logic i_one;
      logic i_inc;
      logic init_wr;
      logic row_rd;
      logic row_st;
      logic cell_rd;
      logic cell_wr;
   } bed_cmd_type;

   typedef struct packed {
      logic la_zero;
      logic lb_zero;
      logic i_at_la;
      logic j_at_lb;
   } bed_stat_type;

endpackage

### sv/bed_ctrl.sv
// Sequencer for loading beats and the row-by-row distance sweep.
module bed_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_op,
   input  bed_pkg::bed_stat_type stat,
   output bed_pkg::bed_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_strobe
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_INIT    = 3'd1;
   localparam logic [2:0] ST_ROW_RD  = 3'd2;
   localparam logic [2:0] ST_ROW_ST  = 3'd3;
   localparam logic [2:0] ST_CELL_RD = 3'd4;
   localparam logic [2:0] ST_CELL_WR = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = start;
            if (start && (req_op == bed_pkg::OP_COMPUTE)) begin
               cmd.j_clear = 1'b1;
               state_in    = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (stat.j_at_lb) begin
               if (stat.la_zero) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.i_one = 1'b1;
                  state_in  = ST_ROW_RD;
               end
            end else begin
               cmd.j_inc = 1'b1;
            end
         end
         ST_ROW_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_ROW_ST;
         end
         ST_ROW_ST: begin
            cmd.row_st = 1'b1;
            cmd.j_one  = 1'b1;
            if (!stat.lb_zero) begin
               state_in = ST_CELL_RD;
            end else if (stat.i_at_la) begin
               state_in = ST_DONE;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = ST_ROW_RD;
            end
         end
         ST_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in    = ST_CELL_WR;
         end
         ST_CELL_WR: begin
            cmd.cell_wr = 1'b1;
            if (!stat.j_at_lb) begin
               cmd.j_inc = 1'b1;
               state_in  = ST_CELL_RD;
            end else if (stat.i_at_la) begin
               state_in = ST_DONE;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = ST_ROW_RD;
            end
         end
         ST_DONE: begin
            cmd.clear = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);

endmodule

### sv/bed_dpath.sv
// String stores, DP row memory, counters and the cell update.
module bed_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  bed_pkg::bed_cmd_type        cmd,
   input  bed_pkg::bed_req_type        req,
   input  logic                        csr_wr,
   input  logic [bed_pkg::THR_W-1:0]   csr_data,
   output bed_pkg::bed_stat_type       stat,
   output bed_pkg::bed_rsp_type        rsp
);

   localparam int LW = bed_pkg::LEN_W;
   localparam int IW = bed_pkg::IDX_W;
   localparam logic [LW-1:0] FULL = LW'(bed_pkg::MAX_LEN);

   logic [7:0]    store_a_ff [bed_pkg::MAX_LEN];
   logic [7:0]    store_b_ff [bed_pkg::MAX_LEN];
   logic [LW-1:0] row_ff     [bed_pkg::MAX_LEN + 1];

   logic [7:0]    a_rdata_ff, b_rdata_ff;
   logic [LW-1:0] up_ff;

   logic [LW-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] i_ff, i_in, j_ff, j_in;
   logic [LW-1:0] left_ff, left_in, diag_ff, diag_in;
   logic [bed_pkg::THR_W-1:0] thr_ff, thr_in;

   logic          wr_a, wr_b, full_a, full_b;
   logic          row_we;
   logic [LW-1:0] row_waddr, row_wdata, row_raddr;
   logic [LW-1:0] i_m1, j_m1;
   logic [LW:0]   sub_c, ins_c, del_c, m1, m2;
   logic [LW-1:0] cell_new;
   logic [bed_pkg::CMP_W-1:0] left_x, thr_x, dist_x;

   assign full_a = (len_a_ff == FULL);
   assign full_b = (len_b_ff == FULL);
   assign wr_a = cmd.accept && (req.op == bed_pkg::OP_APPEND_A) && !full_a;
   assign wr_b = cmd.accept && (req.op == bed_pkg::OP_APPEND_B) && !full_b;

   assign i_m1 = i_ff - LW'(1);
   assign j_m1 = j_ff - LW'(1);

   // cell: min(diag + mismatch, left + 1, up + 1)
   always_comb begin
      sub_c    = {1'b0, diag_ff} + ((a_rdata_ff != b_rdata_ff) ? (LW+1)'(1) : (LW+1)'(0));
      ins_c    = {1'b0, left_ff} + (LW+1)'(1);
      del_c    = {1'b0, up_ff} + (LW+1)'(1);
      m1       = (sub_c < ins_c) ? sub_c : ins_c;
      m2       = (m1 < del_c) ? m1 : del_c;
      cell_new = m2[LW-1:0];
   end

   always_comb begin
      row_we    = cmd.init_wr || cmd.row_st || cmd.cell_wr;
      row_waddr = cmd.row_st ? '0 : j_ff;
      row_wdata = cmd.init_wr ? j_ff : (cmd.row_st ? i_ff : cell_new);
      row_raddr = cmd.row_rd ? '0 : j_ff;
   end

   always_comb begin
      len_a_in = len_a_ff;
      len_b_in = len_b_ff;
      ovf_in   = ovf_ff;
      if (cmd.accept) begin
         case (req.op)
            bed_pkg::OP_APPEND_A: begin
               if (full_a) ovf_in = 1'b1;
               else        len_a_in = len_a_ff + LW'(1);
            end
            bed_pkg::OP_APPEND_B: begin
               if (full_b) ovf_in = 1'b1;
               else        len_b_in = len_b_ff + LW'(1);
            end
            default: begin
            end
         endcase
      end
      if (cmd.clear) begin
         len_a_in = '0;
         len_b_in = '0;
         ovf_in   = 1'b0;
      end

      j_in = j_ff;
      if (cmd.j_clear)    j_in = '0;
      else if (cmd.j_one) j_in = LW'(1);
      else if (cmd.j_inc) j_in = j_ff + LW'(1);

      i_in = i_ff;
      if (cmd.i_one)      i_in = LW'(1);
      else if (cmd.i_inc) i_in = i_ff + LW'(1);

      left_in = left_ff;
      diag_in = diag_ff;
      if (cmd.init_wr) left_in = j_ff;
      if (cmd.row_st) begin
         left_in = i_ff;
         diag_in = up_ff;
      end
      if (cmd.cell_wr) begin
         left_in = cell_new;
         diag_in = up_ff;
      end

      thr_in = csr_wr ? csr_data : thr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff <= '0;
         len_b_ff <= '0;
         ovf_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         thr_ff   <= bed_pkg::THR_RESET;
      end else begin
         len_a_ff <= len_a_in;
         len_b_ff <= len_b_in;
         ovf_ff   <= ovf_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         thr_ff   <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      diag_ff <= diag_in;
   end

   // string stores: one write, one registered read each
   always_ff @(posedge clock) begin
      if (wr_a) store_a_ff[len_a_ff[IW-1:0]] <= req.symbol;
      if (cmd.row_rd) a_rdata_ff <= store_a_ff[i_m1[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) store_b_ff[len_b_ff[IW-1:0]] <= req.symbol;
      if (cmd.cell_rd) b_rdata_ff <= store_b_ff[j_m1[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (row_we) row_ff[row_waddr] <= row_wdata;
      if (cmd.row_rd || cmd.cell_rd) up_ff <= row_ff[row_raddr];
   end

   assign stat.la_zero = (len_a_ff == '0);
   assign stat.lb_zero = (len_b_ff == '0);
   assign stat.i_at_la = (i_ff == len_a_ff);
   assign stat.j_at_lb = (j_ff == len_b_ff);

   always_comb begin
      left_x       = bed_pkg::CMP_W'(left_ff);
      thr_x        = bed_pkg::CMP_W'(thr_ff);
      dist_x       = (left_x > thr_x) ? thr_x : left_x;
      rsp.distance = dist_x[7:0];
      rsp.overflow = ovf_ff;
   end

endmodule

### sv/bounded_edit_distance_top.sv
// Top level of the bounded edit distance block.
// Append beats (op 0 to string A, op 1 to string B) never raise busy. A
// compute beat (op 2) raises busy and sweeps the DP table row by row through
// one row memory with registered reads, each cell passing through a read
// state and a write state. The result is on rsp_data for the single cycle
// that rsp_strobe is high and must be taken then; the same cycle clears both
// strings and the overflow flag. Op 3 is ignored. The threshold register is
// always ready; write it only while busy is low.
module bounded_edit_distance_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  bed_pkg::bed_req_type      req_data,
   output logic                      rsp_strobe,
   output bed_pkg::bed_rsp_type      rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bed_pkg::THR_W-1:0] csr_data
);

   bed_pkg::bed_cmd_type  cmd;
   bed_pkg::bed_stat_type stat;

   assign csr_ready = 1'b1;

   bed_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_data.op),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   bed_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req      (req_data),
      .csr_wr   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .stat     (stat),
      .rsp      (rsp_data)
   );

endmodule

### verif/edit_distance_checker.sv
`timescale 1ns / 100ps
// Checker that predicts capped edit distance results and compares them against rsp beats.
module edit_distance_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  bed_pkg::bed_req_type      req,
   input  logic                      rsp_strobe,
   input  bed_pkg::bed_rsp_type      rsp,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [bed_pkg::THR_W-1:0] csr_data,
   output int                        mismatches,
   output int                        outstanding
);

   logic [7:0]                str_a [bed_pkg::MAX_LEN];
   logic [7:0]                str_b [bed_pkg::MAX_LEN];
   int                        len_a = 0;
   int                        len_b = 0;
   logic                      dropped = 1'b0;
   logic [bed_pkg::THR_W-1:0] cap = bed_pkg::THR_RESET;
   bed_pkg::bed_rsp_type      expected_results[$];
   int                        errors = 0;

   // Row-by-row DP over the loaded strings, then clipped at the cap.
   function automatic int capped_levenshtein();
      int row [bed_pkg::MAX_LEN+1];
      int diag;
      int up;
      int best;
      for (int j = 0; j <= len_b; j++) row[j] = j;
      for (int i = 1; i <= len_a; i++) begin
         diag = row[0];
         row[0] = i;
         for (int j = 1; j <= len_b; j++) begin
            up = row[j];
            best = diag + ((str_a[i-1] != str_b[j-1]) ? 1 : 0);
            if (row[j-1] + 1 < best) best = row[j-1] + 1;
            if (up + 1 < best) best = up + 1;
            row[j] = best;
            diag = up;
         end
      end
      return (row[len_b] > int'(cap)) ? int'(cap) : row[len_b];
   endfunction

   always @(posedge clock) begin : watch
      bed_pkg::bed_rsp_type want;
      if (reset) begin
         len_a = 0;
         len_b = 0;
         dropped = 1'b0;
         cap = bed_pkg::THR_RESET;
         expected_results.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) cap = csr_data;
         if (start && !busy) begin
            case (req.op)
               bed_pkg::OP_APPEND_A: begin
                  if (len_a < bed_pkg::MAX_LEN) begin
                     str_a[len_a] = req.symbol;
                     len_a++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               bed_pkg::OP_APPEND_B: begin
                  if (len_b < bed_pkg::MAX_LEN) begin
                     str_b[len_b] = req.symbol;
                     len_b++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               bed_pkg::OP_COMPUTE: begin
                  want.distance = 8'(capped_levenshtein());
                  want.overflow = dropped;
                  expected_results.push_back(want);
                  len_a = 0;
                  len_b = 0;
                  dropped = 1'b0;
               end
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $error("distance: no result expected, got %0d (overflow %0b)",
                      rsp.distance, rsp.overflow);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp.distance !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, rsp.distance);
                  errors++;
               end
               if (rsp.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp.overflow);
                  errors++;
               end
            end
         end
      end
      mismatches  <= errors;
      outstanding <= expected_results.size();
   end

endmodule

### verif/bounded_edit_distance_top_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives string loads, computes and threshold writes, and reports the verdict.
module bounded_edit_distance_top_tb;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   // The cycle limit leaves wide margin over the worst-case full 64x64 compute.
   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int TARGET_BEATS = 1600;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   bed_pkg::bed_req_type      req = '0;
   logic                      rsp_strobe;
   bed_pkg::bed_rsp_type      rsp;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [bed_pkg::THR_W-1:0] csr_data = '0;
   int                        mismatches;
   int                        outstanding;
   int                        beats_sent = 0;
   int                        cycles = 0;
   bit                        no_gaps = 1'b0;

   bounded_edit_distance_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   edit_distance_checker distance_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [7:0] draw_symbol(input bit narrow, input logic [7:0] base);
      return narrow ? 8'(base + 8'($urandom_range(0, 3))) : 8'($urandom_range(0, 255));
   endfunction

   // One beat; start stays high across back-to-back beats.
   task automatic issue_beat(input logic [1:0] beat_op, input logic [7:0] beat_symbol);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req   <= {beat_op, beat_symbol};
      @(posedge clock);
      while (busy) @(posedge clock);
      if (beat_op != OP_IGNORED) beats_sent++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [bed_pkg::THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Load A and B (interleaved, with some ignored ops mixed in), then compute.
   // A related B is A with random deletes, substitutions and inserts.
   task automatic run_pair(input int a_len, input int b_len, input bit related,
                           input bit narrow);
      logic [7:0] str_a[$];
      logic [7:0] str_b[$];
      logic [7:0] base;
      int         pick;
      base = 8'($urandom_range(0, 255));
      repeat (a_len) str_a.push_back(draw_symbol(narrow, base));
      if (related) begin
         for (int k = 0; k < str_a.size(); k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 1) begin
               str_b.push_back(draw_symbol(narrow, base));
            end else if (pick != 0) begin
               if (pick == 2) str_b.push_back(draw_symbol(narrow, base));
               str_b.push_back(str_a[k]);
            end
         end
      end else begin
         repeat (b_len) str_b.push_back(draw_symbol(narrow, base));
      end
      while (str_a.size() + str_b.size() > 0) begin
         if ($urandom_range(0, 29) == 0)
            issue_beat(OP_IGNORED, 8'($urandom_range(0, 255)));
         if (str_b.size() == 0 || (str_a.size() != 0 && $urandom_range(0, 1) == 1))
            issue_beat(bed_pkg::OP_APPEND_A, str_a.pop_front());
         else
            issue_beat(bed_pkg::OP_APPEND_B, str_b.pop_front());
      end
      issue_beat(bed_pkg::OP_COMPUTE, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int                        phase;
      int                        pick;
      logic [bed_pkg::THR_W-1:0] thr;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset threshold of 30.
      issue_beat(bed_pkg::OP_COMPUTE, 8'hFF);        // both empty
      issue_beat(bed_pkg::OP_APPEND_A, 8'h00);
      issue_beat(bed_pkg::OP_APPEND_A, 8'hFF);
      issue_beat(bed_pkg::OP_COMPUTE, 8'h00);        // B empty
      issue_beat(bed_pkg::OP_APPEND_B, 8'hAA);
      issue_beat(bed_pkg::OP_APPEND_B, 8'h55);
      issue_beat(bed_pkg::OP_APPEND_B, 8'hFF);
      issue_beat(bed_pkg::OP_COMPUTE, 8'h00);        // A empty
      issue_beat(bed_pkg::OP_APPEND_A, 8'h01);
      issue_beat(bed_pkg::OP_APPEND_B, 8'h01);
      issue_beat(bed_pkg::OP_APPEND_A, 8'h02);
      issue_beat(OP_IGNORED, 8'hFF);
      issue_beat(bed_pkg::OP_APPEND_A, 8'h03);
      issue_beat(bed_pkg::OP_APPEND_B, 8'h03);
      issue_beat(bed_pkg::OP_COMPUTE, 8'h00);        // one delete
      issue_beat(bed_pkg::OP_APPEND_A, 8'hC3);
      issue_beat(bed_pkg::OP_APPEND_B, 8'h3C);
      issue_beat(bed_pkg::OP_COMPUTE, 8'h00);        // one substitute
      drain_results();
      write_threshold(8'd0);
      issue_beat(bed_pkg::OP_APPEND_A, 8'h12);
      issue_beat(bed_pkg::OP_APPEND_A, 8'h34);
      issue_beat(bed_pkg::OP_APPEND_B, 8'h56);
      issue_beat(bed_pkg::OP_COMPUTE, 8'h00);        // zero cap

      // Overflow on both strings right away.
      drain_results();
      write_threshold(8'd255);
      run_pair(70, 66, 1'b0, 1'b0);

      phase = 0;
      while (beats_sent < TARGET_BEATS) begin
         drain_results();
         case (phase)
            0: thr = 8'd0;
            1: thr = 8'd255;
            2: thr = 8'd1;
            3: thr = 8'd64;
            default: thr = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 12))
                                                      : 8'($urandom_range(0, 255));
         endcase
         write_threshold(thr);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (8) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               run_pair($urandom_range(56, 72), $urandom_range(56, 72),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick <= 2) begin
               // broken sequences: raw ops with random payload
               repeat ($urandom_range(1, 6))
                  issue_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
               run_pair($urandom_range(0, 10), $urandom_range(0, 10),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
         phase++;
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
